// ----- hdl/mrm_pkg.sv -----
package mrm_pkg;

    localparam int BufferDepth = 128;
    localparam int AddrW       = $clog2(BufferDepth);
    localparam int CallerMax   = 15;
    localparam int CallerW     = $clog2(CallerMax + 1);

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_REARM = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CALLER = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [3:0] PAT_OK   = 4'd0;
    localparam logic [3:0] PAT_RING = 4'd1;
    localparam logic [3:0] PAT_CLIP = 4'd2;
    localparam logic [3:0] PAT_CR   = 4'd3;
    localparam logic [3:0] PAT_NUM  = 4'd9;

    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [2:0] NOTICE_LEN = 3'd7;

    // pattern length
    function automatic logic [3:0] pat_len(input logic [3:0] p);
        logic [3:0] r;
        case (p)
            4'd0: r = 4'd4;
            4'd1: r = 4'd5;
            4'd3: r = 4'd1;
            4'd4: r = 4'd1;
            4'd6: r = 4'd9;
            default: r = 4'd7;
        endcase
        return r;
    endfunction

    // pattern character at position
    function automatic logic [7:0] pat_char(input logic [3:0] p, input logic [3:0] i);
        logic [8*9-1:0] s;
        case (p)
            4'd0: s = {"OK", 8'd13, 8'd10, 40'd0};
            4'd1: s = {"RING", 8'd13, 32'd0};
            4'd2: s = {"+CLIP: ", 16'd0};
            4'd3: s = {8'd13, 64'd0};
            4'd4: s = {">", 64'd0};
            4'd5: s = {"+CPIN: ", 16'd0};
            4'd6: s = "+CGATT: 1";
            4'd7: s = {"+CMTI: ", 16'd0};
            default: s = {"+CMGR: ", 16'd0};
        endcase
        return (i < 4'd9) ? s[8*(8-i) +: 8] : 8'd0;
    endfunction

    function automatic logic [7:0] notice_char(input logic [2:0] i);
        logic [8*7-1:0] s;
        s = "+CMTI: ";
        return (i < 3'd7) ? s[8*(6-i) +: 8] : 8'd0;
    endfunction

endpackage

// ----- hdl/modem_response_matcher_unit.sv -----
// bytes, rearms and reads are captured, handled in S_WORK, and answered from S_DONE
// a completion scan reads the store from 0 to the write position, one store read a cycle
// a new item is taken only in S_IDLE and after the last result beat has been taken
// caller id characters go one beat a cycle unless stalled, then the closing status beat
// reset: asynchronous, active low; clears state and flags; data regs, store undefined
module modem_response_matcher_unit
    import mrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] data_byte,
    input  logic       clear_buffer,
    input  logic [3:0] pattern,
    input  logic       watch_new_sms,
    input  logic [6:0] read_address,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       ack,
    output logic       overflow,
    output logic       incoming_call,
    output logic       new_sms,
    output logic [7:0] sms_index
);

    typedef enum logic [2:0] {
        S_IDLE, S_WORK, S_SCAN, S_SCAN_END, S_EMIT, S_DONE
    } state_t;

    state_t state_reg;
    logic [1:0] req_reg;
    logic [7:0] byte_reg;
    logic       clr_reg, watch_in_reg;
    logic [3:0] pat_in_reg;
    logic [AddrW-1:0] write_pos_reg;
    logic [3:0] active_reg, match_reg;
    logic [2:0] notice_reg;
    logic       recv_reg, ack_reg, ovf_reg, caller_reg, notice_pend_reg, watch_reg;
    logic [7:0] index_reg;
    logic       call_reg, sms_reg;

    // scan
    logic [AddrW:0]   scan_cnt_reg;
    logic [AddrW:0]   scan_len_reg;
    logic             scan_caller_reg, scan_notice_reg;
    logic             sc_valid_reg;
    logic             in_q_reg, q_done_reg, comma_reg;
    logic [7:0]       acc_reg;
    logic [7:0]       cid_reg [CallerMax];
    logic [CallerW-1:0] nid_reg, emit_reg;

    // output register
    logic       ov_reg;
    logic [1:0] kind_reg;
    logic [7:0] ob_reg;
    logic       last_reg;
    logic [7:0] rd_hold_reg;

    logic             wr_en;
    logic [AddrW-1:0] rd_addr;
    logic [7:0]       rd_data;

    mrm_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (byte_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign wr_en    = (state_reg == S_WORK) && (req_reg == REQ_BYTE)
                      && recv_reg && (byte_reg != 8'd0);
    assign rd_addr  = (state_reg == S_IDLE) ? read_address[AddrW-1:0]
                                            : scan_cnt_reg[AddrW-1:0];

    assign out_valid     = ov_reg;
    assign kind          = kind_reg;
    assign out_byte      = ob_reg;
    assign last          = last_reg;
    assign ack           = ack_reg;
    assign overflow      = ovf_reg;
    assign incoming_call = call_reg;
    assign new_sms       = sms_reg;
    assign sms_index     = index_reg;

    // matcher decode for current byte
    logic [3:0] p_eff;
    logic       pat_hit, pat_end, note_hit;
    always_comb
    begin
        p_eff    = (active_reg < PAT_NUM) ? active_reg : PAT_OK;
        pat_hit  = (match_reg < pat_len(p_eff)) && (pat_char(p_eff, match_reg) == byte_reg);
        pat_end  = pat_hit && ((match_reg + 4'd1) >= pat_len(p_eff));
        note_hit = watch_reg && (notice_reg < NOTICE_LEN)
                   && (notice_char(notice_reg) == byte_reg);
    end

    logic out_take;
    assign out_take = ov_reg && out_ready;

    logic [AddrW:0] wp_inc;
    assign wp_inc = {1'b0, write_pos_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_pos_reg   <= '0;
            active_reg      <= PAT_OK;
            match_reg       <= '0;
            notice_reg      <= '0;
            recv_reg        <= 1'b0;
            ack_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            caller_reg      <= 1'b0;
            notice_pend_reg <= 1'b0;
            watch_reg       <= 1'b0;
            index_reg       <= '0;
            call_reg        <= 1'b0;
            sms_reg         <= 1'b0;
            ov_reg          <= 1'b0;
            sc_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg      <= req_type;
                        byte_reg     <= data_byte;
                        clr_reg      <= clear_buffer;
                        pat_in_reg   <= pattern;
                        watch_in_reg <= watch_new_sms;
                        call_reg     <= 1'b0;
                        sms_reg      <= 1'b0;
                        nid_reg      <= '0;
                        state_reg    <= S_WORK;
                    end
                end
                S_WORK:
                begin
                    kind_reg  <= KIND_STATUS;
                    ob_reg    <= 8'd0;
                    last_reg  <= 1'b1;
                    state_reg <= S_DONE;
                    if (req_reg == REQ_READ)
                    begin
                        kind_reg <= KIND_READ;
                        ob_reg   <= rd_data;
                    end
                    else if (req_reg == REQ_REARM)
                    begin
                        if (clr_reg)
                        begin
                            write_pos_reg   <= '0;
                            notice_reg      <= '0;
                            ack_reg         <= 1'b0;
                            ovf_reg         <= 1'b0;
                            caller_reg      <= 1'b0;
                            notice_pend_reg <= 1'b0;
                        end
                        if (pat_in_reg < PAT_NUM)
                        begin
                            active_reg <= pat_in_reg;
                        end
                        match_reg <= '0;
                        watch_reg <= watch_in_reg;
                        recv_reg  <= 1'b1;
                    end
                    else if (wr_en)
                    begin
                        write_pos_reg <= wp_inc[AddrW-1:0];
                        if (wp_inc[AddrW])
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (pat_hit)
                        begin
                            match_reg <= match_reg + 4'd1;
                            if (pat_end)
                            begin
                                match_reg <= '0;
                                if (p_eff == PAT_RING)
                                begin
                                    active_reg    <= PAT_CLIP;
                                    write_pos_reg <= '0;
                                end
                                else if (p_eff == PAT_CLIP)
                                begin
                                    active_reg    <= PAT_CR;
                                    write_pos_reg <= '0;
                                    caller_reg    <= 1'b1;
                                end
                                else
                                begin
                                    ack_reg  <= 1'b1;
                                    recv_reg <= 1'b0;
                                    if (caller_reg || notice_pend_reg)
                                    begin
                                        // scan the store up to the wrapped write position
                                        caller_reg      <= 1'b0;
                                        notice_pend_reg <= 1'b0;
                                        call_reg        <= caller_reg;
                                        sms_reg         <= notice_pend_reg;
                                        scan_caller_reg <= caller_reg;
                                        scan_notice_reg <= notice_pend_reg;
                                        scan_len_reg    <= {1'b0, wp_inc[AddrW-1:0]};
                                        scan_cnt_reg    <= '0;
                                        sc_valid_reg    <= 1'b0;
                                        in_q_reg        <= 1'b0;
                                        q_done_reg      <= 1'b0;
                                        comma_reg       <= 1'b0;
                                        acc_reg         <= '0;
                                        state_reg       <= S_SCAN;
                                    end
                                end
                            end
                        end
                        else if (note_hit)
                        begin
                            notice_reg <= notice_reg + 3'd1;
                            match_reg  <= '0;
                            if (notice_reg + 3'd1 >= NOTICE_LEN)
                            begin
                                notice_reg      <= '0;
                                active_reg      <= PAT_CR;
                                write_pos_reg   <= '0;
                                notice_pend_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            match_reg  <= '0;
                            notice_reg <= '0;
                        end
                    end
                end
                S_SCAN, S_SCAN_END:
                begin
                    // address issue
                    if (state_reg == S_SCAN)
                    begin
                        sc_valid_reg <= scan_cnt_reg < scan_len_reg;
                        if (scan_cnt_reg < scan_len_reg)
                        begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_END;
                        end
                    end
                    else
                    begin
                        sc_valid_reg <= 1'b0;
                        emit_reg     <= '0;
                        if (scan_notice_reg)
                        begin
                            index_reg <= comma_reg ? acc_reg : 8'd0;
                        end
                        state_reg <= (nid_reg != '0) ? S_EMIT : S_DONE;
                        if (nid_reg == '0)
                        begin
                            kind_reg <= KIND_STATUS;
                            ob_reg   <= 8'd0;
                            last_reg <= 1'b1;
                        end
                    end
                    // data consume
                    if (sc_valid_reg)
                    begin
                        if (scan_caller_reg && !q_done_reg)
                        begin
                            if (!in_q_reg)
                            begin
                                in_q_reg <= (rd_data == CH_QUOTE);
                            end
                            else if (rd_data == CH_QUOTE)
                            begin
                                q_done_reg <= 1'b1;
                            end
                            else if (nid_reg < CallerW'(CallerMax))
                            begin
                                cid_reg[nid_reg] <= rd_data;
                                nid_reg          <= nid_reg + 1'b1;
                            end
                        end
                        if (scan_notice_reg)
                        begin
                            if (!comma_reg)
                            begin
                                comma_reg <= (rd_data == CH_COMMA);
                            end
                            else if (rd_data >= CH_ZERO && rd_data <= CH_NINE)
                            begin
                                acc_reg <= 8'((acc_reg << 3) + (acc_reg << 1)
                                              + (rd_data - CH_ZERO));
                            end
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || out_take)
                    begin
                        ov_reg   <= 1'b1;
                        kind_reg <= KIND_CALLER;
                        ob_reg   <= cid_reg[emit_reg];
                        last_reg <= 1'b0;
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg + 1'b1 == nid_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg || out_take)
                    begin
                        ov_reg    <= 1'b1;
                        kind_reg  <= KIND_STATUS;
                        ob_reg    <= 8'd0;
                        last_reg  <= 1'b1;
                        if (req_reg == REQ_READ)
                        begin
                            kind_reg <= KIND_READ;
                            ob_reg   <= rd_hold_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // read data held until the result beat goes out
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WORK)
        begin
            rd_hold_reg <= rd_data;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_store_write_only_recv: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> recv_reg)
        else $error("store written while not receiving");
    a_caller_only_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_CALLER) |-> !last)
        else $error("caller beat marked last");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_reg < nid_reg))
        else $error("emit index past caller count");
`endif

endmodule

// ----- hdl/mrm_store.sv -----
module mrm_store
    import mrm_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [BufferDepth];

    // single write, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
